/* design/utf8d_pkg.sv */
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the UTF-8 byte stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int unsigned CP_W = 21;

    localparam logic [7:0] LEAD1_MAX = 8'h7F;
    localparam logic [7:0] LEAD2_MIN = 8'hC0;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD4_MAX = 8'hF7;
    localparam logic [7:0] CONT_MIN  = 8'h80;
    localparam logic [7:0] CONT_MAX  = 8'hBF;
    localparam logic [7:0] CONT_MASK = 8'h3F;

    localparam logic [CP_W-1:0] FLOOR_TWO   = 21'h00007F;
    localparam logic [CP_W-1:0] FLOOR_THREE = 21'h0007FF;
    localparam logic [CP_W-1:0] FLOOR_FOUR  = 21'h00FFFF;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // continuation bytes of the current sequence
    localparam logic [1:0] SEQ_NONE  = 2'd0;
    localparam logic [1:0] SEQ_TWO   = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } t_in_beat;

    typedef struct packed {
        logic [CP_W-1:0] char_value;
        logic            status;
        logic            string_done;
    } t_result;

endpackage

/* design/utf8d_in_stage.sv */
// ----------------------------------------------------------------------------
// utf8d_in_stage
// Input register: holds one byte beat until the decoder takes it.
// ----------------------------------------------------------------------------
module utf8d_in_stage
    import utf8d_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_beat i_beat,
    input  logic     i_advance,
    output logic     o_stall,
    output logic     o_valid,
    output t_in_beat o_beat
);

    logic     r_valid;
    logic     n_valid;
    t_in_beat r_beat;
    logic     load;

    assign o_stall = r_valid && !i_advance;
    assign load    = i_valid && !o_stall;
    assign n_valid = load || (r_valid && !i_advance);
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_beat <= i_beat;
        end
    end

endmodule

/* design/utf8d_decode.sv */
// ----------------------------------------------------------------------------
// utf8d_decode
// Sequence state and per-byte decode: gathers code point bits, checks lead,
// continuation, overlong and cut-off rules, and drops bytes after an error.
// ----------------------------------------------------------------------------
module utf8d_decode
    import utf8d_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_beat i_beat,
    input  logic     i_out_ready,
    output logic     o_advance,
    output logic     o_push,
    output t_result  o_result
);

    logic [1:0]      r_pending;
    logic [1:0]      n_pending;
    logic [CP_W-1:0] r_partial;
    logic [CP_W-1:0] n_partial;
    logic [1:0]      r_seq;
    logic [1:0]      n_seq;
    logic            r_disc;
    logic            n_disc;

    logic [7:0]      byte_in;
    logic            eos;
    logic [1:0]      left;
    logic [CP_W-1:0] cont_bits;
    logic [CP_W-1:0] gathered;
    logic [CP_W-1:0] floor_value;
    logic [CP_W-1:0] good_cp;
    logic            is_cont;
    logic            do_err;
    logic            do_val;
    logic            has_res;
    logic            fire;

    assign byte_in  = i_beat.data_byte;
    assign eos      = i_beat.end_of_string;
    assign left     = r_pending - 2'd1;
    assign is_cont  = (byte_in >= CONT_MIN) && (byte_in <= CONT_MAX);
    assign gathered = r_partial | cont_bits;

    always_comb begin
        unique case (left)
            2'd0:    cont_bits = {15'd0, byte_in[5:0]};
            2'd1:    cont_bits = {9'd0, byte_in[5:0], 6'd0};
            2'd2:    cont_bits = {3'd0, byte_in[5:0], 12'd0};
            default: cont_bits = {byte_in[2:0], 18'd0};
        endcase
    end

    always_comb begin
        unique case (r_seq)
            SEQ_TWO:   floor_value = FLOOR_TWO;
            SEQ_THREE: floor_value = FLOOR_THREE;
            default:   floor_value = FLOOR_FOUR;
        endcase
    end

    always_comb begin
        n_pending = r_pending;
        n_partial = r_partial;
        n_seq     = r_seq;
        n_disc    = r_disc;
        do_err    = 1'b0;
        do_val    = 1'b0;
        good_cp   = '0;
        if (r_disc) begin
            if (eos) begin
                n_disc = 1'b0;
            end
        end else if (r_pending == 2'd0) begin
            priority if (byte_in <= LEAD1_MAX) begin
                do_val  = 1'b1;
                good_cp = {13'd0, byte_in};
            end else if (byte_in >= LEAD2_MIN && byte_in <= LEAD2_MAX) begin
                n_partial = {10'd0, byte_in[4:0], 6'd0};
                n_seq     = SEQ_TWO;
                n_pending = SEQ_TWO;
                do_err    = eos;
            end else if (byte_in >= LEAD3_MIN && byte_in <= LEAD3_MAX) begin
                n_partial = {5'd0, byte_in[3:0], 12'd0};
                n_seq     = SEQ_THREE;
                n_pending = SEQ_THREE;
                do_err    = eos;
            end else if (byte_in >= LEAD4_MIN && byte_in <= LEAD4_MAX) begin
                n_partial = {byte_in[2:0], 18'd0};
                n_seq     = SEQ_FOUR;
                n_pending = SEQ_FOUR;
                do_err    = eos;
            end else begin
                do_err = 1'b1;
            end
        end else begin
            if (!is_cont) begin
                do_err = 1'b1;
            end else begin
                n_pending = left;
                n_partial = gathered;
                if (left != 2'd0) begin
                    do_err = eos;
                end else if (gathered <= floor_value) begin
                    do_err = 1'b1;
                end else begin
                    do_val  = 1'b1;
                    good_cp = gathered;
                end
            end
        end

        if (do_err) begin
            n_pending = 2'd0;
            n_partial = '0;
            n_seq     = SEQ_NONE;
            n_disc    = !eos;
        end else if (do_val) begin
            n_pending = 2'd0;
            n_partial = '0;
            n_seq     = SEQ_NONE;
        end
    end

    assign has_res   = do_err || do_val;
    assign o_advance = !has_res || i_out_ready;
    assign fire      = i_valid && o_advance;
    assign o_push    = fire && has_res;

    always_comb begin
        if (do_err) begin
            o_result.char_value  = '0;
            o_result.status      = STATUS_ERR;
            o_result.string_done = 1'b1;
        end else begin
            o_result.char_value  = good_cp;
            o_result.status      = STATUS_OK;
            o_result.string_done = eos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_partial <= '0;
            r_seq     <= SEQ_NONE;
            r_disc    <= 1'b0;
        end else if (fire) begin
            r_pending <= n_pending;
            r_partial <= n_partial;
            r_seq     <= n_seq;
            r_disc    <= n_disc;
        end
    end

`ifndef ASSERT_OFF
    a_disc_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_disc |-> (r_pending == 2'd0) && (r_seq == SEQ_NONE))
        else $error("discarding with a sequence open");

    a_pending_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending != 2'd0) |-> (r_seq != SEQ_NONE) && (r_pending <= r_seq))
        else $error("pending count outside sequence length");

    a_disc_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_disc) |-> !o_push)
        else $error("result while discarding");

    a_err_starts_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && (o_result.status == STATUS_ERR) && !eos) |=> r_disc)
        else $error("error mid-string did not start discarding");

    a_disc_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_disc && !eos) |=> r_disc)
        else $error("discarding ended before end of string");
`endif

endmodule

/* design/utf8d_out_stage.sv */
// ----------------------------------------------------------------------------
// utf8d_out_stage
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module utf8d_out_stage
    import utf8d_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_ready  = !r_valid || !i_stall;
    assign n_valid  = i_push || (r_valid && i_stall);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_result <= i_result;
        end
    end

endmodule

/* design/utf8_byte_stream_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder
// UTF-8 byte stream to code point decoder.
//
// Input channel: one byte per beat (i_data_byte, i_end_of_string) on
// i_in_valid / o_in_stall. Output channel: one result beat per completed
// sequence or error (o_char_value, o_status, o_string_done) on o_out_valid /
// i_out_stall. Lead bytes and inner continuation bytes of a sequence and
// bytes dropped after an error give no output beat.
// Throughput: one byte per cycle, set by the single decode step between
// the input register and the result register, when the input is not stalled.
// Errors give one beat with status set, code point zero and string_done
// set; later bytes of that string are dropped up to the end flag.
// Reset (synchronous, active low) empties both registers and clears the
// sequence state. When the receiver stalls, the result register holds;
// bytes that give no result still pass, and the input stalls only once a
// byte with a result finds the result register full.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder
    import utf8d_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [7:0]      i_data_byte,
    input  logic            i_end_of_string,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [CP_W-1:0] o_char_value,
    output logic            o_status,
    output logic            o_string_done
);

    t_in_beat in_beat;
    t_in_beat s1_beat;
    logic     s1_valid;
    logic     advance;
    logic     out_ready;
    logic     push;
    t_result  dec_result;
    t_result  out_result;

    assign in_beat.data_byte     = i_data_byte;
    assign in_beat.end_of_string = i_end_of_string;

    utf8d_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_beat    (in_beat),
        .i_advance (advance),
        .o_stall   (o_in_stall),
        .o_valid   (s1_valid),
        .o_beat    (s1_beat)
    );

    utf8d_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s1_valid),
        .i_beat      (s1_beat),
        .i_out_ready (out_ready),
        .o_advance   (advance),
        .o_push      (push),
        .o_result    (dec_result)
    );

    utf8d_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (dec_result),
        .i_stall  (i_out_stall),
        .o_ready  (out_ready),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_char_value  = out_result.char_value;
    assign o_status      = out_result.status;
    assign o_string_done = out_result.string_done;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UTF-8 byte stream decoder.
//
// Bytes are sent as strings, each string ending on a byte with the
// end-of-string flag set. A short directed set covers the field extremes
// and each error case. A random set follows, made mostly of well-formed
// sequences, with corrupted, overlong and cut-off sequences and raw noise
// mixed in. A tracker class decodes every accepted byte itself and keeps
// the code points it expects. Each result beat is compared with the oldest
// of them. Both sides idle at random, the receiver holds off once for a long
// stretch, and the sender lets the output drain once mid-run and at the end.
// ----------------------------------------------------------------------------
module testbench;
    import utf8d_pkg::*;

    typedef logic [7:0] t_byte_q[$];

    class char_tracker;
        logic [1:0]      conts_left;
        logic [CP_W-1:0] gathered;
        logic [1:0]      seq_kind;
        bit              dropping;
        t_result         pending_points[$];
        int unsigned     failures;

        function new();
            conts_left = 2'd0;
            gathered   = '0;
            seq_kind   = SEQ_NONE;
            dropping   = 1'b0;
            failures   = 0;
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= 10) begin
                $display("%0t: %s", $realtime, msg);
            end
        endfunction

        function int outstanding();
            return pending_points.size();
        endfunction

        function void push_point(logic [CP_W-1:0] cp, logic eos);
            t_result r;
            conts_left = 2'd0;
            gathered   = '0;
            seq_kind   = SEQ_NONE;
            r.char_value  = cp;
            r.status      = STATUS_OK;
            r.string_done = eos;
            pending_points.insert(pending_points.size(), r);
        endfunction

        function void push_abort(logic eos);
            t_result r;
            conts_left = 2'd0;
            gathered   = '0;
            seq_kind   = SEQ_NONE;
            dropping   = !eos;
            r.char_value  = '0;
            r.status      = STATUS_ERR;
            r.string_done = 1'b1;
            pending_points.insert(pending_points.size(), r);
        endfunction

        // accepted input beat
        function void take_byte(logic [7:0] b, logic eos);
            logic [CP_W-1:0] floor_cp;
            if (dropping) begin
                if (eos) begin
                    dropping = 1'b0;
                end
                return;
            end
            if (conts_left == 2'd0) begin
                if (b <= LEAD1_MAX) begin
                    push_point(CP_W'(b), eos);
                    return;
                end
                if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
                    gathered = CP_W'(b[4:0]) << 6;
                    seq_kind = SEQ_TWO;
                end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
                    gathered = CP_W'(b[3:0]) << 12;
                    seq_kind = SEQ_THREE;
                end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
                    gathered = CP_W'(b[2:0]) << 18;
                    seq_kind = SEQ_FOUR;
                end else begin
                    push_abort(eos);
                    return;
                end
                conts_left = seq_kind;
                if (eos) begin
                    push_abort(eos);
                end
                return;
            end
            if (b < CONT_MIN || b > CONT_MAX) begin
                push_abort(eos);
                return;
            end
            conts_left = conts_left - 2'd1;
            gathered = gathered | (CP_W'(b & CONT_MASK) << (6 * conts_left));
            if (conts_left != 2'd0) begin
                if (eos) begin
                    push_abort(eos);
                end
                return;
            end
            if (seq_kind == SEQ_TWO) begin
                floor_cp = FLOOR_TWO;
            end else if (seq_kind == SEQ_THREE) begin
                floor_cp = FLOOR_THREE;
            end else begin
                floor_cp = FLOOR_FOUR;
            end
            if (gathered <= floor_cp) begin
                push_abort(eos);
            end else begin
                push_point(gathered, eos);
            end
        endfunction

        // accepted output beat
        function void match_result(logic [CP_W-1:0] cp, logic st, logic done);
            t_result e;
            if (pending_points.size() == 0) begin
                note_failure($sformatf("unexpected beat cp=%h st=%0d done=%0d",
                                       cp, st, done));
                return;
            end
            e = pending_points.pop_front();
            if (cp !== e.char_value || st !== e.status || done !== e.string_done) begin
                note_failure($sformatf({"mismatch: expected cp=%h st=%0d done=%0d,",
                                        " got cp=%h st=%0d done=%0d"},
                                       e.char_value, e.status, e.string_done,
                                       cp, st, done));
            end
        endfunction
    endclass

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_in_valid = 1'b0;
    logic            o_in_stall;
    logic [7:0]      i_data_byte = 8'h00;
    logic            i_end_of_string = 1'b0;
    logic            o_out_valid;
    logic            i_out_stall = 1'b0;
    logic [CP_W-1:0] o_char_value;
    logic            o_status;
    logic            o_string_done;

    char_tracker tracker = new();
    bit          hold_req = 1'b0;
    bit          no_idle = 1'b0;
    int unsigned random_bytes = 0;

    utf8_byte_stream_decoder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_string (i_end_of_string),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_char_value    (o_char_value),
        .o_status        (o_status),
        .o_string_done   (o_string_done)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.match_result(o_char_value, o_status, o_string_done);
        end
    end

    // result side back-pressure
    initial begin
        int n;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                n = 100;
            end else begin
                n = no_idle ? 0 : $urandom_range(0, 6);
            end
            if (n != 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        #5ms;
        $display("[utf8_byte_stream_decoder] ERROR");
        $finish;
    end

    task automatic send_byte(logic [7:0] b, logic eos);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_data_byte     <= b;
        i_end_of_string <= eos;
        do @(posedge i_clk); while (o_in_stall);
        tracker.take_byte(b, eos);
    endtask

    task automatic send_string(t_byte_q s);
        for (int i = 0; i < s.size(); i++) begin
            send_byte(s[i], i == s.size() - 1);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.outstanding() != 0);
    endtask

    function automatic t_byte_q random_string();
        t_byte_q         s;
        int              n;
        int              kind;
        logic [CP_W-1:0] cp;
        s = {};
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) s.insert(s.size(), 8'($urandom_range(0, 255)));
            return s;
        end
        n = $urandom_range(1, 6);
        repeat (n) begin
            kind = $urandom_range(1, 4);
            case (kind)
                1: cp = CP_W'($urandom_range(0, 'h7F));
                2: cp = CP_W'($urandom_range('h80, 'h7FF));
                3: cp = CP_W'($urandom_range('h800, 'hFFFF));
                default: cp = CP_W'($urandom_range('h10000, 'h1FFFFF));
            endcase
            // overlong form
            if (kind > 1 && $urandom_range(0, 19) == 0) begin
                cp = CP_W'($urandom_range(0, kind == 2 ? 'h7F : kind == 3 ? 'h7FF : 'hFFFF));
            end
            case (kind)
                1: s.insert(s.size(), cp[7:0]);
                2: begin
                    s.insert(s.size(), {3'b110, cp[10:6]});
                    s.insert(s.size(), {2'b10, cp[5:0]});
                end
                3: begin
                    s.insert(s.size(), {4'b1110, cp[15:12]});
                    s.insert(s.size(), {2'b10, cp[11:6]});
                    s.insert(s.size(), {2'b10, cp[5:0]});
                end
                default: begin
                    s.insert(s.size(), {5'b11110, cp[20:18]});
                    s.insert(s.size(), {2'b10, cp[17:12]});
                    s.insert(s.size(), {2'b10, cp[11:6]});
                    s.insert(s.size(), {2'b10, cp[5:0]});
                end
            endcase
            if ($urandom_range(0, 24) == 0) begin
                s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
            end
        end
        // cut off mid-string
        if (s.size() > 1 && $urandom_range(0, 14) == 0) begin
            n = $urandom_range(1, s.size() - 1);
            while (s.size() > n) void'(s.pop_back());
        end
        return s;
    endfunction

    initial begin
        t_byte_q s;
        bit      hold_done;
        bit      drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // smallest value of each length, then largest of one, two and four bytes
        send_string('{8'h00, 8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80,
                      8'hF0, 8'h90, 8'h80, 8'h80});
        send_string('{8'h7F, 8'hDF, 8'hBF, 8'hF7, 8'hBF, 8'hBF, 8'hBF});
        // overlong two-byte form, rest of string dropped
        send_string('{8'hC0, 8'h80, 8'h41});
        // stray lead
        send_string('{8'hFF});
        // bad continuation, not reread as a lead
        send_string('{8'hC2, 8'h41});
        // string ends inside a sequence
        send_string('{8'hE2, 8'h82});
        // overlong three- and four-byte forms
        send_string('{8'hE0, 8'h9F, 8'hBF});
        send_string('{8'hF0, 8'h8F, 8'hBF, 8'hBF});

        while (random_bytes < 2000) begin
            if (!hold_done && random_bytes >= 500) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
                no_idle   = 1'b1;
                s = {};
                repeat (40) s.insert(s.size(), 8'($urandom_range('h20, 'h7E)));
                send_string(s);
                no_idle = 1'b0;
            end
            if (!drain_done && random_bytes >= 1000) begin
                drain_done = 1'b1;
                drain();
            end
            no_idle = (random_bytes >= 1300 && random_bytes < 1600);
            s = random_string();
            random_bytes += s.size();
            send_string(s);
        end
        no_idle = 1'b0;

        drain();
        repeat (8) @(posedge i_clk);
        if (tracker.outstanding() != 0) begin
            tracker.note_failure("results never arrived");
        end
        if (tracker.failures == 0) begin
            $display("[utf8_byte_stream_decoder] OK");
        end else begin
            $display("[utf8_byte_stream_decoder] ERROR");
        end
        $finish;
    end

endmodule
